// ----- hdl/stcr_pkg.sv -----
// stcr_pkg: shared constants, types and state codes of the sphere tet clip renumber block
// used by stcr_vertex_map and sphere_tet_clip_renumber_top; depends on nothing else
`timescale 1ns / 1ps

package stcr_pkg;

    // field widths
    localparam int COORD_BITS = 16;
    localparam int ID_W       = 16;
    localparam int IDX_W      = 16;
    localparam int CFG_W      = 32;
    localparam int CFG_IDX_W  = 2;

    // vertex map geometry (power of two depth)
    localparam int MAX_NODES  = 65536;
    localparam int MAP_AW     = $clog2(MAX_NODES);

    // datapath widths: four-corner coordinate sums, their squares, sum of three squares
    localparam int SUM_W      = COORD_BITS + 2;
    localparam int SQ_W       = 2 * SUM_W;
    localparam int ACC_W      = SQ_W + 2;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS_SQ      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOUNDARY_LIMIT = 2'd1;

    // corner slot of the fourth corner
    localparam logic [1:0] LAST_CORNER = 2'd3;

    // one vertex map entry
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
    } map_entry_t;

    // request from the sequencer to the vertex map
    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic [MAP_AW-1:0] addr;
        map_entry_t        wr_data;
    } map_req_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_CMP,
        ST_TMUL,
        ST_TCMP,
        ST_READ,
        ST_WRITE
    } state_t;

endpackage

// ----- hdl/stcr_vertex_map.sv -----
// stcr_vertex_map: vertex map memory with registered read and a clearing pass
// after reset; depends on stcr_pkg
`timescale 1ns / 1ps

module stcr_vertex_map
(
    input  logic                clk,
    input  logic                rst_n,
    input  stcr_pkg::map_req_t  req,
    output stcr_pkg::map_entry_t rd_data,
    output logic                busy
);

    stcr_pkg::map_entry_t mem [stcr_pkg::MAX_NODES];

    logic [stcr_pkg::MAP_AW-1:0] clr_addr_reg;
    logic [stcr_pkg::MAP_AW-1:0] clr_addr_next;
    logic                        busy_reg;
    logic                        busy_next;
    stcr_pkg::map_entry_t        rd_data_reg;

    logic                        mem_we;
    logic [stcr_pkg::MAP_AW-1:0] mem_waddr;
    stcr_pkg::map_entry_t        mem_wdata;

    // clearing sweep, one entry a cycle
    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        busy_next     = busy_reg;
        if (busy_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == {stcr_pkg::MAP_AW{1'b1}})
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            busy_reg     <= 1'b1;
        end
        else
        begin
            clr_addr_reg <= clr_addr_next;
            busy_reg     <= busy_next;
        end
    end

    // write port: sweep has priority while it runs
    always_comb
    begin
        if (busy_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = req.wr_en;
            mem_waddr = req.addr;
            mem_wdata = req.wr_data;
        end
    end

    // memory array with registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (req.rd_en && !busy_reg)
        begin
            rd_data_reg <= mem[req.addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = busy_reg;

    // the requester stays off the memory until the sweep is done
    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (!req.wr_en && !req.rd_en))
        else $error("vertex map accessed during clearing pass");

    // the sweep ends only after the last entry
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> ($past(clr_addr_reg) == {stcr_pkg::MAP_AW{1'b1}}))
        else $error("clearing pass ended early");

    // the sweep runs once after reset
    assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |=> !busy_reg)
        else $error("clearing pass restarted");

endmodule

// ----- hdl/sphere_tet_clip_renumber_top.sv -----
// sphere_tet_clip_renumber_top: corner buffer, squaring datapath, renumber sequencer
// depends on stcr_pkg and stcr_vertex_map
`timescale 1ns / 1ps

// Usage
// Input channel: one tetrahedron corner per item (vertex_id, coord_x/y/z, corner_last),
// taken at a rising edge with in_valid high and in_stall low. Output channel: one
// renumbered corner per item, four per kept tetrahedron, tet_last on the fourth.
// Configuration: cfg_we writes cfg_data into the register at cfg_index
// (radius_sq, boundary_limit); write only while the block is idle.
// Timing: corners one to three each go through square, compare, then back to idle.
// A fourth corner goes on to the keep test on the corner sums; a kept tetrahedron then does four
// read-modify-write passes on the vertex map, each a registered read, then a write-back;
// no new corner is taken until the last pass is done. Each result shows in the cycle
// after its write-back.
// Reset: the vertex map is swept to unmapped, one entry a cycle, with in_stall held high;
// configuration writes are taken during the sweep.
// Output stall: a result waits in the output register; the sequencer holds its
// write-back until the register is free. New corners are taken while a result waits.

module sphere_tet_clip_renumber_top
(
    input  logic                                   clk,
    input  logic                                   rst_n,

    input  logic                                   cfg_we,
    input  logic [stcr_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [stcr_pkg::CFG_W-1:0]             cfg_data,

    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [stcr_pkg::ID_W-1:0]              vertex_id,
    input  logic signed [stcr_pkg::COORD_BITS-1:0] coord_x,
    input  logic signed [stcr_pkg::COORD_BITS-1:0] coord_y,
    input  logic signed [stcr_pkg::COORD_BITS-1:0] coord_z,
    input  logic                                   corner_last,

    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [stcr_pkg::ID_W-1:0]              source_id,
    output logic [stcr_pkg::IDX_W-1:0]             compact_index,
    output logic                                   first_use,
    output logic                                   on_boundary,
    output logic                                   tet_last
);

    // configuration registers
    logic [stcr_pkg::CFG_W-1:0] radius_sq_reg;
    logic [stcr_pkg::CFG_W-1:0] boundary_limit_reg;

    // control state
    stcr_pkg::state_t           state_reg;
    stcr_pkg::state_t           state_next;
    logic [1:0]                 corner_count_reg;
    logic [1:0]                 corner_count_next;
    logic [1:0]                 slot_reg;
    logic [1:0]                 slot_next;
    logic [stcr_pkg::IDX_W-1:0] next_index_reg;
    logic [stcr_pkg::IDX_W-1:0] next_index_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;

    // corner buffer and current corner
    logic [stcr_pkg::ID_W-1:0]              corner_ids_reg [4];
    logic                                   corner_flags_reg [4];
    logic signed [stcr_pkg::COORD_BITS-1:0] coord_reg [3];
    logic                                   last_reg;
    logic signed [stcr_pkg::SUM_W-1:0]      sum_reg [3];

    // squaring datapath
    logic signed [stcr_pkg::SUM_W-1:0] mul_op [3];
    logic [stcr_pkg::SUM_W-1:0]        mul_abs [3];
    logic [stcr_pkg::SQ_W-1:0]         sq_reg [3];
    logic [stcr_pkg::ACC_W-1:0]        sq_total;
    logic                              far_flag;
    logic                              tet_kept;

    // output register payload
    logic [stcr_pkg::ID_W-1:0]  source_id_reg;
    logic [stcr_pkg::IDX_W-1:0] compact_index_reg;
    logic                       first_use_reg;
    logic                       on_boundary_reg;
    logic                       tet_last_reg;

    // sequencer outputs
    logic                       in_accept;
    logic                       out_free;
    logic                       out_load;
    logic                       map_miss;
    logic [stcr_pkg::IDX_W-1:0] result_idx;
    stcr_pkg::map_req_t         map_req;
    stcr_pkg::map_entry_t       map_rd_data;
    logic                       map_busy;

    stcr_vertex_map u_vertex_map
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (map_req),
        .rd_data (map_rd_data),
        .busy    (map_busy)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_sq_reg      <= '0;
            boundary_limit_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                stcr_pkg::REG_RADIUS_SQ:      radius_sq_reg      <= cfg_data;
                stcr_pkg::REG_BOUNDARY_LIMIT: boundary_limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // multiplier operands: corner coordinates or four-corner sums
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            if (state_reg == stcr_pkg::ST_TMUL)
            begin
                mul_op[j] = sum_reg[j];
            end
            else
            begin
                mul_op[j] = stcr_pkg::SUM_W'(coord_reg[j]);
            end
            mul_abs[j] = mul_op[j][stcr_pkg::SUM_W-1] ? (~mul_op[j] + 1'b1) : mul_op[j];
        end
    end

    // three squaring lanes, registered
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 3; j++)
        begin
            sq_reg[j] <= stcr_pkg::SQ_W'(mul_abs[j]) * stcr_pkg::SQ_W'(mul_abs[j]);
        end
    end

    // sum of squares and the two comparisons
    assign sq_total = stcr_pkg::ACC_W'(sq_reg[0]) + stcr_pkg::ACC_W'(sq_reg[1])
                    + stcr_pkg::ACC_W'(sq_reg[2]);
    assign far_flag = sq_total >= stcr_pkg::ACC_W'(boundary_limit_reg);
    assign tet_kept = sq_total <= stcr_pkg::ACC_W'({radius_sq_reg, 4'b0000});

    // map lookup result
    assign map_miss   = !map_rd_data.valid;
    assign result_idx = map_miss ? next_index_reg : map_rd_data.idx;
    assign out_free   = !out_valid_reg || !out_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            stcr_pkg::ST_IDLE:
            begin
                if (in_valid && !map_busy)
                begin
                    state_next = stcr_pkg::ST_MUL;
                end
            end
            stcr_pkg::ST_MUL:  state_next = stcr_pkg::ST_CMP;
            stcr_pkg::ST_CMP:
            begin
                if (corner_count_reg == stcr_pkg::LAST_CORNER)
                begin
                    state_next = stcr_pkg::ST_TMUL;
                end
                else
                begin
                    state_next = stcr_pkg::ST_IDLE;
                end
            end
            stcr_pkg::ST_TMUL: state_next = stcr_pkg::ST_TCMP;
            stcr_pkg::ST_TCMP:
            begin
                state_next = tet_kept ? stcr_pkg::ST_READ : stcr_pkg::ST_IDLE;
            end
            stcr_pkg::ST_READ: state_next = stcr_pkg::ST_WRITE;
            stcr_pkg::ST_WRITE:
            begin
                if (out_free)
                begin
                    if (slot_reg == stcr_pkg::LAST_CORNER)
                    begin
                        state_next = stcr_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = stcr_pkg::ST_READ;
                    end
                end
            end
            default: state_next = stcr_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_stall          = 1'b1;
        out_load          = 1'b0;
        map_req           = '0;
        map_req.addr      = stcr_pkg::MAP_AW'(corner_ids_reg[slot_reg]);
        map_req.wr_data   = '{valid: 1'b1, idx: next_index_reg};
        corner_count_next = corner_count_reg;
        slot_next         = slot_reg;
        next_index_next   = next_index_reg;
        case (state_reg)
            stcr_pkg::ST_IDLE:
            begin
                in_stall = map_busy;
            end
            stcr_pkg::ST_CMP:
            begin
                if (corner_count_reg != stcr_pkg::LAST_CORNER)
                begin
                    corner_count_next = last_reg ? 2'd0 : corner_count_reg + 1'b1;
                end
            end
            stcr_pkg::ST_TCMP:
            begin
                corner_count_next = 2'd0;
                slot_next         = 2'd0;
            end
            stcr_pkg::ST_READ:
            begin
                map_req.rd_en = 1'b1;
            end
            stcr_pkg::ST_WRITE:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    slot_next     = slot_reg + 1'b1;
                    map_req.wr_en = map_miss;
                    if (map_miss)
                    begin
                        next_index_next = next_index_reg + 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    assign in_accept = in_valid && !in_stall;

    // output valid tracking
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= stcr_pkg::ST_IDLE;
            corner_count_reg <= '0;
            slot_reg         <= '0;
            next_index_reg   <= '0;
            out_valid_reg    <= 1'b0;
            for (int j = 0; j < 3; j++)
            begin
                sum_reg[j] <= '0;
            end
        end
        else
        begin
            state_reg        <= state_next;
            corner_count_reg <= corner_count_next;
            slot_reg         <= slot_next;
            next_index_reg   <= next_index_next;
            out_valid_reg    <= out_valid_next;
            // running sums: accumulate on accept, clear when the tetrahedron closes or an early last mark drops it
            if (in_accept)
            begin
                sum_reg[0] <= sum_reg[0] + stcr_pkg::SUM_W'(coord_x);
                sum_reg[1] <= sum_reg[1] + stcr_pkg::SUM_W'(coord_y);
                sum_reg[2] <= sum_reg[2] + stcr_pkg::SUM_W'(coord_z);
            end
            else if ((state_reg == stcr_pkg::ST_TCMP)
                  || (state_reg == stcr_pkg::ST_CMP && last_reg
                      && corner_count_reg != stcr_pkg::LAST_CORNER))
            begin
                for (int j = 0; j < 3; j++)
                begin
                    sum_reg[j] <= '0;
                end
            end
        end
    end

    // corner capture and boundary flag
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            corner_ids_reg[corner_count_reg] <= vertex_id;
            coord_reg[0]                     <= coord_x;
            coord_reg[1]                     <= coord_y;
            coord_reg[2]                     <= coord_z;
            last_reg                         <= corner_last;
        end
        if (state_reg == stcr_pkg::ST_CMP)
        begin
            corner_flags_reg[corner_count_reg] <= far_flag;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            source_id_reg     <= corner_ids_reg[slot_reg];
            compact_index_reg <= result_idx;
            first_use_reg     <= map_miss;
            on_boundary_reg   <= map_miss && corner_flags_reg[slot_reg];
            tet_last_reg      <= (slot_reg == stcr_pkg::LAST_CORNER);
        end
    end

    assign out_valid     = out_valid_reg;
    assign source_id     = source_id_reg;
    assign compact_index = compact_index_reg;
    assign first_use     = first_use_reg;
    assign on_boundary   = on_boundary_reg;
    assign tet_last      = tet_last_reg;

    // the compact index advances only together with a new map entry
    assert property (@(posedge clk) disable iff (!rst_n)
        (next_index_reg != $past(next_index_reg)) |-> $past(map_req.wr_en))
        else $error("compact index advanced without a map write");

    // a result goes into the output register only when it is free
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || !out_stall))
        else $error("output register overwritten");

    // the fourth result ends the renumber pass
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && slot_reg == stcr_pkg::LAST_CORNER) |=> (state_reg == stcr_pkg::ST_IDLE))
        else $error("renumber pass did not end after fourth result");

    // closing a tetrahedron restarts the corner count
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == stcr_pkg::ST_TCMP) |=> (corner_count_reg == 2'd0))
        else $error("corner count not cleared at tetrahedron close");

    // no corner is taken during a map access
    assert property (@(posedge clk) disable iff (!rst_n)
        (map_req.rd_en || map_req.wr_en) |-> !in_accept)
        else $error("corner accepted during renumber pass");

endmodule

// ----- test/sphere_tet_clip_renumber_top_test.sv -----
// sphere_tet_clip_renumber_top_test: self-checking bench for the tet clip and renumber block
// depends on stcr_pkg and sphere_tet_clip_renumber_top; checks every result against its own
// scoreboard of renumbered corners built from the corners the block accepts
`timescale 1ns / 1ps

module sphere_tet_clip_renumber_top_test;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 40;
    localparam int LONG_HOLD    = 300;

    // one tetrahedron corner as offered on the input channel
    typedef struct {
        logic [stcr_pkg::ID_W-1:0]              id;
        logic signed [stcr_pkg::COORD_BITS-1:0] x;
        logic signed [stcr_pkg::COORD_BITS-1:0] y;
        logic signed [stcr_pkg::COORD_BITS-1:0] z;
        logic                                   last;
    } corner_t;

    // one renumbered corner as given on the output channel
    typedef struct {
        logic [stcr_pkg::ID_W-1:0]  source_id;
        logic [stcr_pkg::IDX_W-1:0] compact_index;
        logic                       first_use;
        logic                       on_boundary;
        logic                       tet_last;
    } renumbered_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                           cfg_we = 1'b0;
    logic [stcr_pkg::CFG_IDX_W-1:0] cfg_index = stcr_pkg::REG_RADIUS_SQ;
    logic [stcr_pkg::CFG_W-1:0]     cfg_data = '0;

    logic                                   in_valid = 1'b0;
    logic                                   in_stall;
    logic [stcr_pkg::ID_W-1:0]              vertex_id = '0;
    logic signed [stcr_pkg::COORD_BITS-1:0] coord_x = '0;
    logic signed [stcr_pkg::COORD_BITS-1:0] coord_y = '0;
    logic signed [stcr_pkg::COORD_BITS-1:0] coord_z = '0;
    logic                                   corner_last = 1'b0;

    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic [stcr_pkg::ID_W-1:0]  source_id;
    logic [stcr_pkg::IDX_W-1:0] compact_index;
    logic                       first_use;
    logic                       on_boundary;
    logic                       tet_last;

    sphere_tet_clip_renumber_top dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .vertex_id     (vertex_id),
        .coord_x       (coord_x),
        .coord_y       (coord_y),
        .coord_z       (coord_z),
        .corner_last   (corner_last),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .source_id     (source_id),
        .compact_index (compact_index),
        .first_use     (first_use),
        .on_boundary   (on_boundary),
        .tet_last      (tet_last)
    );

    // corners waiting to be offered, renumbered corners waiting to come out
    corner_t     corner_q[$];
    renumbered_t renumbered_q[$];

    // shadow of the block: registers, vertex map, corner buffer
    logic [stcr_pkg::CFG_W-1:0] radius_lim = '0;
    logic [stcr_pkg::CFG_W-1:0] edge_limit = '0;
    bit                         map_used [0:stcr_pkg::MAX_NODES-1];
    int unsigned                map_index [0:stcr_pkg::MAX_NODES-1];
    int unsigned                free_index = 0;
    logic [stcr_pkg::ID_W-1:0]  held_id [0:3];
    bit                         held_edge [0:3];
    longint                     sum_x = 0;
    longint                     sum_y = 0;
    longint                     sum_z = 0;
    int unsigned                corner_cnt = 0;

    int  errors = 0;
    int  cycles = 0;
    bit  quiet = 1'b0;
    bit  in_fire = 1'b0;
    int  gap_left = 0;
    int  stall_left = 0;
    int  hold_left = 0;
    int  hold_asked = 0;
    int  hold_served = 0;
    corner_t next_corner;

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    // corner buffer, keep test and vertex renumbering for one accepted corner
    task automatic predict_corner();
        longint      cx;
        longint      cy;
        longint      cz;
        longint      d2;
        longint      s2;
        int unsigned slot;
        renumbered_t r;
        cx = coord_x;
        cy = coord_y;
        cz = coord_z;
        d2 = cx * cx + cy * cy + cz * cz;
        held_id[corner_cnt]   = vertex_id;
        held_edge[corner_cnt] = (d2 >= longint'({32'd0, edge_limit}));
        sum_x += cx;
        sum_y += cy;
        sum_z += cz;
        if (corner_cnt < 3)
        begin
            // early last mark drops the partial tet
            if (corner_last)
            begin
                sum_x = 0;
                sum_y = 0;
                sum_z = 0;
                corner_cnt = 0;
            end
            else
                corner_cnt++;
        end
        else
        begin
            // fourth corner closes the tet whatever its last mark
            s2 = sum_x * sum_x + sum_y * sum_y + sum_z * sum_z;
            if (s2 <= 16 * longint'({32'd0, radius_lim}))
            begin
                for (int i = 0; i < 4; i++)
                begin
                    slot = held_id[i] % stcr_pkg::MAX_NODES;
                    r.source_id = held_id[i];
                    if (map_used[slot])
                    begin
                        r.compact_index = map_index[slot][stcr_pkg::IDX_W-1:0];
                        r.first_use     = 1'b0;
                        r.on_boundary   = 1'b0;
                    end
                    else
                    begin
                        map_used[slot]  = 1'b1;
                        map_index[slot] = free_index;
                        r.compact_index = free_index[stcr_pkg::IDX_W-1:0];
                        r.first_use     = 1'b1;
                        r.on_boundary   = held_edge[i];
                        free_index++;
                    end
                    r.tet_last = (i == 3);
                    renumbered_q = {renumbered_q, r};
                end
            end
            sum_x = 0;
            sum_y = 0;
            sum_z = 0;
            corner_cnt = 0;
        end
    endtask

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    task automatic check_result();
        renumbered_t want;
        if (renumbered_q.size() == 0)
        begin
            $display("%0t: unexpected item, expected none, actual id %0d index %0d flags %b%b%b",
                     $time, source_id, compact_index, first_use, on_boundary, tet_last);
            errors++;
        end
        else
        begin
            want = renumbered_q.pop_front();
            check_field("source_id", want.source_id, source_id);
            check_field("compact_index", want.compact_index, compact_index);
            check_field("first_use", 16'(want.first_use), 16'(first_use));
            check_field("on_boundary", 16'(want.on_boundary), 16'(on_boundary));
            check_field("tet_last", 16'(want.tet_last), 16'(tet_last));
        end
    endtask

    // monitor: results first, then the corner taken at this edge
    always @(posedge clk)
    begin
        in_fire <= rst_n && in_valid && !in_stall;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                check_result();
            if (in_valid && !in_stall)
                predict_corner();
        end
    end

    // driver: next corner once the current one is taken, with random gaps
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_fire))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (!quiet && $urandom_range(9) == 0)
            begin
                gap_left = $urandom_range(17);
                in_valid <= 1'b0;
            end
            else if (corner_q.size() > 0)
            begin
                next_corner = corner_q.pop_front();
                vertex_id   <= next_corner.id;
                coord_x     <= next_corner.x;
                coord_y     <= next_corner.y;
                coord_z     <= next_corner.z;
                corner_last <= next_corner.last;
                in_valid    <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver: one long hold-off on request, otherwise random stall bursts
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (hold_served < hold_asked)
        begin
            hold_served++;
            hold_left = LONG_HOLD - 1;
            out_stall <= 1'b1;
        end
        else if (quiet)
            out_stall <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(7) == 0)
        begin
            stall_left = $urandom_range(17);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    task automatic write_reg(logic [stcr_pkg::CFG_IDX_W-1:0] idx,
                             logic [stcr_pkg::CFG_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        if (idx == stcr_pkg::REG_RADIUS_SQ)
            radius_lim = value;
        else
            edge_limit = value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // wait until every corner is taken and every renumbered corner is out
    task automatic drain();
        while (corner_q.size() > 0 || in_valid || renumbered_q.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic reconfigure(logic [stcr_pkg::CFG_W-1:0] rad,
                               logic [stcr_pkg::CFG_W-1:0] lim);
        drain();
        write_reg(stcr_pkg::REG_RADIUS_SQ, rad);
        write_reg(stcr_pkg::REG_BOUNDARY_LIMIT, lim);
    endtask

    task automatic add_corner(int id, int x, int y, int z, bit last);
        corner_t c;
        c.id   = id[stcr_pkg::ID_W-1:0];
        c.x    = x[stcr_pkg::COORD_BITS-1:0];
        c.y    = y[stcr_pkg::COORD_BITS-1:0];
        c.z    = z[stcr_pkg::COORD_BITS-1:0];
        c.last = last;
        corner_q = {corner_q, c};
    endtask

    function automatic int rand_coord(int span);
        if ($urandom_range(15) == 0)
            return int'($urandom_range(65535)) - 32768;
        return int'($urandom_range(2 * span)) - span;
    endfunction

    function automatic int rand_id(int base);
        if ($urandom_range(6) == 0)
            return $urandom_range(65535);
        return base + $urandom_range(39);
    endfunction

    // mostly whole tets from a small id pool, some broken ones and stray corners
    task automatic add_random_tets(int target, int span, int base);
        int added;
        int pick;
        int n;
        bit marked;
        added = 0;
        while (added < target)
        begin
            pick = $urandom_range(99);
            marked = 1'b1;
            if (pick < 78)
                n = 4;
            else if (pick < 88)
                n = $urandom_range(1, 3);
            else if (pick < 94)
            begin
                n = 4;
                marked = 1'b0;
            end
            else
            begin
                n = 1;
                marked = 1'($urandom_range(1));
            end
            for (int k = 1; k <= n; k++)
                add_corner(rand_id(base), rand_coord(span), rand_coord(span),
                           rand_coord(span), marked && (k == n));
            added += n;
        end
    endtask

    // stimulus and phases
    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // widest keep radius, every new vertex on the boundary
        reconfigure(32'hFFFF_FFFF, 32'd0);
        add_corner(0, 32767, 32767, 32767, 1'b0);
        add_corner(65535, 32767, 32767, 32767, 1'b0);
        add_corner(16'h5555, 32767, 32767, 32767, 1'b0);
        add_corner(16'hAAAA, 32767, 32767, 32767, 1'b1);
        add_corner(1, -32768, -32768, -32768, 1'b0);
        add_corner(2, -32768, -32768, -32768, 1'b0);
        add_corner(3, -32768, -32768, -32768, 1'b0);
        add_corner(65535, -32768, -32768, -32768, 1'b1);
        // early last mark on the first, second and third corner
        add_corner(20, 5, 5, 5, 1'b1);
        add_corner(21, 5, 5, 5, 1'b0);
        add_corner(22, 5, 5, 5, 1'b1);
        add_corner(23, 5, 5, 5, 1'b0);
        add_corner(24, 5, 5, 5, 1'b0);
        add_corner(25, 5, 5, 5, 1'b1);
        // fourth corner without its last mark
        add_corner(30, 100, -200, 300, 1'b0);
        add_corner(31, -100, 200, -300, 1'b0);
        add_corner(32, 0, 0, 0, 1'b0);
        add_corner(0, 1, 1, 1, 1'b0);
        // same vertex repeated inside one tet
        add_corner(7, 10, 20, 30, 1'b0);
        add_corner(7, 10, 20, 30, 1'b0);
        add_corner(8, -10, -20, -30, 1'b0);
        add_corner(7, 10, 20, 30, 1'b1);

        // zero radius: only a zero coordinate sum is kept, nothing on the boundary
        reconfigure(32'd0, 32'hFFFF_FFFF);
        add_corner(40, 100, -50, 7, 1'b0);
        add_corner(41, -100, 50, -7, 1'b0);
        add_corner(42, 3000, 2, -1, 1'b0);
        add_corner(43, -3000, -2, 1, 1'b1);
        add_corner(44, 1, 0, 0, 1'b0);
        add_corner(45, 0, 0, 0, 1'b0);
        add_corner(46, 0, 0, 0, 1'b0);
        add_corner(47, 0, 0, 0, 1'b1);
        add_random_tets(30, 2000, 1000);

        // small sphere, receiver holds off long enough to back up the input
        reconfigure(32'd64_000_000, 32'd51_840_000);
        add_random_tets(140, 10400, 1020);
        hold_asked++;

        // larger sphere
        reconfigure(32'd400_000_000, 32'd324_000_000);
        add_random_tets(110, 26000, 1040);

        // no idling on either side
        reconfigure(32'hFFFF_FFFF, 32'd400_000_000);
        quiet = 1'b1;
        add_random_tets(70, 32767, 1060);

        drain();
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
